[hdl/b64d_pkg.sv]
package b64d_pkg;

    // APB register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_DROP_JUNK = 3'd0;

    // Special characters
    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_LF  = 8'h0A;  // line feed

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_END     = 2'd2
    } t_status;

    // Alphabet lookup result
    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_sextet;

    // Map one character of the standard alphabet to its 6-bit value
    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet r;
        r.hit   = 1'b1;
        r.value = 6'd0;
        if (ch inside {[8'h41:8'h5A]}) begin
            r.value = 6'(ch - 8'h41);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            r.value = 6'(ch - 8'h61 + 8'd26);
        end else if (ch inside {[8'h30:8'h39]}) begin
            r.value = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2B) begin
            r.value = 6'd62;
        end else if (ch == 8'h2F) begin
            r.value = 6'd63;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

[hdl/b64d_if.sv]
// Input channel: one character or end-of-stream marker per transaction
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_stream;

    modport source (output valid, output in_char, output end_of_stream, input ready);
    modport sink   (input valid, input in_char, input end_of_stream, output ready);
endinterface

// Output channel: one result per input transaction
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    output ready);
endinterface

[hdl/b64d_cfg.sv]
module b64d_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [b64d_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [b64d_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [b64d_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic                              o_drop_junk
);

    logic r_drop_junk;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // drop_junk register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_junk <= 1'b0;
        end else if (wr_en && paddr == b64d_pkg::ADDR_DROP_JUNK) begin
            r_drop_junk <= pwdata[0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr == b64d_pkg::ADDR_DROP_JUNK) begin
            prdata[0] = r_drop_junk;
        end
    end

    assign o_drop_junk = r_drop_junk;

endmodule

[hdl/b64d_core.sv]
module b64d_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_drop_junk,
    b64d_in_if.sink         i_in_ch,
    b64d_out_if.source      o_out_ch
);

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_eos;

    // Decoder state
    logic [1:0] r_phase, n_phase;
    logic [5:0] r_left, n_left;
    logic       r_pad2, n_pad2;
    logic       r_err, n_err;

    // Result register
    logic                r_out_vld;
    logic [7:0]          r_out_byte;
    logic                r_out_bvalid;
    b64d_pkg::t_status   r_out_status;

    logic                res_bvalid;
    logic [7:0]          res_byte;
    b64d_pkg::t_status   res_status;
    b64d_pkg::t_sextet   sx;

    logic out_free;
    logic advance;

    // Handshake: result slot frees when empty or taken this cycle
    assign out_free       = !r_out_vld || o_out_ch.ready;
    assign advance        = r_in_vld && out_free;
    assign i_in_ch.ready  = !r_in_vld || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_vld <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_char <= i_in_ch.in_char;
            r_in_eos  <= i_in_ch.end_of_stream;
        end
    end

    // Decode one character against the current state
    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_pad2     = r_pad2;
        n_err      = r_err;
        res_bvalid = 1'b0;
        res_byte   = 8'd0;
        sx         = b64d_pkg::sextet_of(r_in_char);
        if (r_in_eos) begin
            // final check, then back to reset state
            if (r_err || r_phase != 2'd0 || r_pad2) begin
                res_status = b64d_pkg::ST_INVALID;
            end else begin
                res_status = b64d_pkg::ST_END;
            end
            n_phase = 2'd0;
            n_left  = 6'd0;
            n_pad2  = 1'b0;
            n_err   = 1'b0;
        end else begin
            if (!r_err && r_in_char != b64d_pkg::CHAR_LF) begin
                if (r_in_char == b64d_pkg::CHAR_PAD) begin
                    if (r_pad2) begin
                        n_pad2  = 1'b0;
                        n_phase = 2'd0;
                    end else if (r_phase == 2'd2) begin
                        n_pad2 = 1'b1;
                    end else if (r_phase == 2'd3) begin
                        n_phase = 2'd0;
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (!sx.hit) begin
                    if (!i_drop_junk) begin
                        n_err = 1'b1;
                    end
                end else if (r_pad2) begin
                    // alphabet character where the second pad belongs
                    n_err = 1'b1;
                end else begin
                    case (r_phase)
                        2'd0: begin
                            n_left  = sx.value;
                            n_phase = 2'd1;
                        end
                        2'd1: begin
                            res_byte   = {r_left, sx.value[5:4]};
                            res_bvalid = 1'b1;
                            n_left     = {2'b00, sx.value[3:0]};
                            n_phase    = 2'd2;
                        end
                        2'd2: begin
                            res_byte   = {r_left[3:0], sx.value[5:2]};
                            res_bvalid = 1'b1;
                            n_left     = {4'b0000, sx.value[1:0]};
                            n_phase    = 2'd3;
                        end
                        default: begin
                            res_byte   = {r_left[1:0], sx.value};
                            res_bvalid = 1'b1;
                            n_left     = 6'd0;
                            n_phase    = 2'd0;
                        end
                    endcase
                end
            end
            res_status = n_err ? b64d_pkg::ST_INVALID : b64d_pkg::ST_OK;
        end
    end

    // State update on each item moved to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_left  <= 6'd0;
            r_pad2  <= 1'b0;
            r_err   <= 1'b0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pad2  <= n_pad2;
            r_err   <= n_err;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte   <= res_byte;
            r_out_bvalid <= res_bvalid;
            r_out_status <= res_status;
        end
    end

    assign o_out_ch.valid      = r_out_vld;
    assign o_out_ch.out_byte   = r_out_byte;
    assign o_out_ch.byte_valid = r_out_bvalid;
    assign o_out_ch.status     = r_out_status;

endmodule

[hdl/base64_stream_decoder.sv]
// Channel   Dir  Payload                                  Transaction
// i_in_ch   in   in_char[7:0], end_of_stream              one character or end marker
// o_out_ch  out  out_byte[7:0], byte_valid, status[1:0]   one result per input
// APB       in   drop_junk at byte address 0              register write/read
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes through the input register, then is decoded into the result register.
// Decoder state updates as each item moves into the result register.
// Reset (i_rst_n low, synchronous) clears state, the valid flags of both registers and config.
// A stalled output holds its result; the input register keeps taking one
// more item, then input ready drops until the result is taken.
module base64_stream_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    b64d_in_if.sink                           i_in_ch,
    b64d_out_if.source                        o_out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [b64d_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [b64d_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [b64d_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic drop_junk;

    // Configuration register
    b64d_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_drop_junk      (drop_junk)
    );

    // Decode datapath
    b64d_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_drop_junk      (drop_junk),
        .i_in_ch          (i_in_ch),
        .o_out_ch         (o_out_ch)
    );

endmodule
